/* hdl/fmtm_pkg.sv */
// Shared types and codes for the file magic trie matcher.
// No dependencies; imported by every module of the block.
`default_nettype none

package fmtm_pkg;

  typedef enum logic [1:0] {
    CMD_WR_TRANS = 2'd0,
    CMD_WR_ATTR  = 2'd1,
    CMD_START    = 2'd2,
    CMD_DATA     = 2'd3
  } fmtm_cmd_t;

  localparam logic [1:0] ST_CONTINUE   = 2'd0;
  localparam logic [1:0] ST_IDENTIFIED = 2'd1;
  localparam logic [1:0] ST_UNKNOWN    = 2'd2;
  localparam logic [1:0] ST_ACCEPTED   = 2'd3;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    fmtm_cmd_t   cmd;
    logic [7:0]  node_index;
    logic [7:0]  byte_value;
    logic [7:0]  next_index;
    logic        next_present;
    logic [15:0] node_offset;
    logic [9:0]  node_type;
    logic        node_shared;
  } fmtm_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] file_type;
  } fmtm_out_t;

  // Classified request as it waits in the queue.
  typedef struct packed {
    fmtm_cmd_t   cmd;
    logic        node_ok;
    logic [7:0]  node;
    logic [7:0]  byte_value;
    logic        tr_valid;
    logic [7:0]  tr_next;
    logic [15:0] offset;
    logic [9:0]  type_id;
    logic        shared;
  } fmtm_op_t;

  typedef struct packed {
    logic     valid;
    fmtm_op_t op;
  } fmtm_head_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } fmtm_bstat_t;

endpackage

`default_nettype wire

/* hdl/fmtm_front.sv */
// Front end: accepts requests, range-checks and classifies them, and holds
// them in a two-entry queue for the back end. Depends on fmtm_pkg.
`default_nettype none

module fmtm_front
  import fmtm_pkg::*;
#(
  parameter int NODES    = 256,
  parameter int TYPE_IDS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  fmtm_in_t    in_item,
  input  fmtm_bstat_t bstat,
  output fmtm_head_t  head
);

  fmtm_op_t   op_c;
  fmtm_op_t   q_r [QUEUE_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;

  always_comb begin
    op_c.cmd        = in_item.cmd;
    op_c.node_ok    = ({24'd0, in_item.node_index} < NODES);
    op_c.node       = in_item.node_index;
    op_c.byte_value = in_item.byte_value;
    // a target outside the table is stored as null
    op_c.tr_valid   = in_item.next_present && ({24'd0, in_item.next_index} < NODES);
    op_c.tr_next    = in_item.next_index;
    op_c.offset     = in_item.node_offset;
    op_c.type_id    = ({22'd0, in_item.node_type} < TYPE_IDS) ? in_item.node_type : 10'd0;
    op_c.shared     = in_item.node_shared;
  end

  assign in_ready   = (count_r != 2'(QUEUE_DEPTH)) && !bstat.clearing;
  assign push       = in_valid && in_ready;
  assign head.valid = (count_r != 2'd0);
  assign head.op    = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        q_r[wr_ptr_r] <= op_c;
        wr_ptr_r      <= !wr_ptr_r;
      end
      if (bstat.pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, bstat.pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/fmtm_back.sv */
// Back end: transition and attribute memories, the trie walk, the latched
// verdict and the result register. Depends on fmtm_pkg.
`default_nettype none

module fmtm_back
  import fmtm_pkg::*;
#(
  parameter int NODES       = 256,
  parameter int TYPE_IDS    = 1024,
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  fmtm_head_t  head,
  output fmtm_bstat_t bstat,
  output logic        out_valid,
  input  logic        out_ready,
  output fmtm_out_t   out_item
);

  localparam int NW    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int TA    = NW + 8;
  localparam int TDEPTH = NODES * 256;
  localparam int TW    = ($clog2(TYPE_IDS) < 10) ? $clog2(TYPE_IDS) : 10;
  localparam int OB    = OFFSET_BITS;

  typedef struct packed {
    logic [OB-1:0] off;
    logic [TW-1:0] tid;
    logic          shared;
  } attr_t;

  typedef struct packed {
    logic          valid;
    logic [NW-1:0] nxt;
  } trans_t;

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_WALK, B_DECIDE} bstate_t;

  trans_t  trans_mem [TDEPTH];
  attr_t   attr_mem  [NODES];

  bstate_t       state_r;
  logic [NW-1:0] cur_r;
  logic          live_r;
  logic [OB-1:0] pos_r;
  logic [TW-1:0] found_r;
  logic [1:0]    verdict_r;
  logic          finished_r;
  logic [TA-1:0] clr_cnt_r;
  logic          hit_r;
  attr_t         cache_r;
  attr_t         root_r;
  trans_t        trans_q;
  attr_t         attr_q;
  logic          out_valid_r;
  fmtm_out_t     out_item_r;

  fmtm_op_t      op;
  logic          out_free;
  logic [NW-1:0] node_w;
  attr_t         attr_wr;
  trans_t        trans_wr;
  logic          pop_idle;
  logic          pop_dec;
  logic          pop;
  logic          rd_trans;
  logic [TA-1:0] rd_addr;
  logic          wr_trans;
  logic          wr_attr;
  logic          hit_w;
  logic [NW-1:0] attr_addr;

  // decision signals for the byte in the last step
  logic          d_live;
  logic [NW-1:0] d_node;
  logic [TW-1:0] d_ft;
  logic [OB-1:0] d_pos;
  logic [1:0]    d_verdict;
  logic          d_finished;
  logic          d_move;
  logic [NW-1:0] d_cur;

  assign op       = head.op;
  assign out_free = !out_valid_r || out_ready;
  assign node_w   = NW'(op.node);

  always_comb begin
    attr_wr.off    = OB'(op.offset);
    attr_wr.tid    = TW'(op.type_id);
    attr_wr.shared = op.shared;
    trans_wr.valid = op.tr_valid;
    trans_wr.nxt   = op.tr_valid ? NW'(op.tr_next) : '0;
  end

  // walk decision, valid in the decide step
  always_comb begin
    d_ft       = (hit_r && (cache_r.tid != '0)) ? cache_r.tid : found_r;
    d_live     = hit_r ? trans_q.valid : live_r;
    d_node     = hit_r ? trans_q.nxt : cur_r;
    d_pos      = (pos_r == '1) ? pos_r : pos_r + 1'b1;
    d_move     = 1'b0;
    d_finished = 1'b1;
    d_verdict  = ST_UNKNOWN;
    if (finished_r) begin
      d_ft      = found_r;
      d_pos     = pos_r;
      d_verdict = verdict_r;
    end else if (!d_live) begin
      d_verdict = (d_ft != '0) ? ST_IDENTIFIED : ST_UNKNOWN;
    end else if ((d_ft != '0) && attr_q.shared) begin
      d_verdict = ST_IDENTIFIED;
    end else if (attr_q.off > pos_r) begin
      d_verdict  = ST_CONTINUE;
      d_finished = 1'b0;
      d_move     = 1'b1;
    end
    d_cur = d_move ? d_node : cur_r;
  end

  assign pop_idle = (state_r == B_IDLE) && head.valid && ((op.cmd == CMD_DATA) || out_free);
  assign pop_dec  = (state_r == B_DECIDE) && out_free && head.valid && (op.cmd == CMD_DATA);
  assign pop      = pop_idle || pop_dec;
  assign rd_trans = pop && (op.cmd == CMD_DATA);
  assign rd_addr  = {((state_r == B_DECIDE) ? d_cur : cur_r), op.byte_value};
  assign wr_trans = pop_idle && (op.cmd == CMD_WR_TRANS) && op.node_ok;
  assign wr_attr  = pop_idle && (op.cmd == CMD_WR_ATTR) && op.node_ok;

  assign hit_w     = !finished_r && live_r && (cache_r.off == pos_r);
  assign attr_addr = (hit_w && trans_q.valid) ? trans_q.nxt : cur_r;

  always_ff @(posedge clk) begin
    if (state_r == B_CLEAR) begin
      trans_mem[clr_cnt_r] <= '0;
    end else if (wr_trans) begin
      trans_mem[{node_w, op.byte_value}] <= trans_wr;
    end
    if (rd_trans) begin
      trans_q <= trans_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_attr) begin
      attr_mem[node_w] <= attr_wr;
    end
    if (state_r == B_WALK) begin
      attr_q <= attr_mem[attr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      cur_r       <= '0;
      live_r      <= 1'b1;
      pos_r       <= '0;
      found_r     <= '0;
      verdict_r   <= ST_CONTINUE;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == TA'(TDEPTH - 1)) begin
            state_r <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (pop_idle) begin
            if (op.cmd == CMD_DATA) begin
              state_r <= B_WALK;
            end else begin
              out_valid_r          <= 1'b1;
              out_item_r.status    <= ST_ACCEPTED;
              out_item_r.file_type <= '0;
            end
            if (wr_attr) begin
              // keep the cached copies of the current node and the root in step
              if (node_w == cur_r) begin
                cache_r <= attr_wr;
              end
              if (node_w == '0) begin
                root_r <= attr_wr;
              end
            end
            if (op.cmd == CMD_START) begin
              cur_r      <= '0;
              live_r     <= 1'b1;
              pos_r      <= '0;
              found_r    <= '0;
              verdict_r  <= ST_CONTINUE;
              finished_r <= 1'b0;
              cache_r    <= root_r;
            end
          end
        end
        B_WALK: begin
          hit_r   <= hit_w;
          state_r <= B_DECIDE;
        end
        B_DECIDE: begin
          if (out_free) begin
            out_valid_r          <= 1'b1;
            out_item_r.status    <= d_verdict;
            out_item_r.file_type <= 10'(d_ft);
            pos_r                <= d_pos;
            found_r              <= d_ft;
            verdict_r            <= d_verdict;
            finished_r           <= d_finished;
            live_r               <= finished_r ? live_r : d_live;
            cur_r                <= d_cur;
            if (d_move) begin
              cache_r <= attr_q;
            end
            state_r <= pop_dec ? B_WALK : B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign bstat.clearing = (state_r == B_CLEAR);
  assign bstat.pop      = pop;
  assign out_valid      = out_valid_r;
  assign out_item       = out_item_r;

endmodule

`default_nettype wire

/* hdl/file_magic_trie_matcher.sv */
// File magic trie matcher top level: front end, request queue, back end.
// Depends on fmtm_pkg, fmtm_front and fmtm_back.
//
// Identifies a file type from the leading bytes of a stream by walking a trie
// loaded through table-write requests; each request returns one result. After
// reset the transition table is swept to null, during which no request is taken.
// Requests enter a two-entry queue; each data byte goes through a transition
// memory read and then an attribute memory read before its result is
// registered, and the next byte's transition read overlaps that decision.
// Table writes and start are taken only from idle, so after a data byte they
// wait until its result is registered. Verdicts latch until the next start.
`default_nettype none

module file_magic_trie_matcher
  import fmtm_pkg::*;
#(
  parameter int NODES       = 256,
  parameter int TYPE_IDS    = 1024,
  parameter int OFFSET_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fmtm_in_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output fmtm_out_t out_item
);

  fmtm_head_t  head;
  fmtm_bstat_t bstat;

  fmtm_front #(
    .NODES    (NODES),
    .TYPE_IDS (TYPE_IDS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .bstat    (bstat),
    .head     (head)
  );

  fmtm_back #(
    .NODES       (NODES),
    .TYPE_IDS    (TYPE_IDS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .bstat     (bstat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_clear_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.clearing |-> !in_ready)
    else $error("request taken during table clear");

  a_clear_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.clearing |-> !out_valid)
    else $error("result shown during table clear");

  a_accept_no_type: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == ST_ACCEPTED)) |-> (out_item.file_type == 10'd0))
    else $error("command result carries a file type");

  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.pop |-> head.valid)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

/* test/file_magic_trie_matcher_tb.sv */
// Testbench for file_magic_trie_matcher: trie loads, directed walks, far offsets, random walks.
// Depends on fmtm_pkg and the file_magic_trie_matcher top level; predicts every result itself.
`default_nettype none

module file_magic_trie_matcher_tb;
  import fmtm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int PRINT_CAP     = 40;
  localparam int DRAIN_CYCLES  = 20;
  localparam int PHASE_ITEMS   = 370;
  localparam int FAR_OFFSET    = 200;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  fmtm_in_t  in_item;
  logic      out_valid;
  logic      out_ready = 1'b0;
  fmtm_out_t out_item;

  file_magic_trie_matcher u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  // Shadow of the trie and of the walk context.
  logic [8:0]  trans_mem   [0:65535];
  logic [15:0] attr_off    [0:255];
  logic [9:0]  attr_type   [0:255];
  logic        attr_shared [0:255];
  bit          attr_written[0:255];
  logic [7:0]  child_label [0:255];
  bit          has_child   [0:255];
  logic [7:0]  written_nodes[$];

  logic [7:0]  walk_node;
  logic [15:0] walk_pos;
  logic [9:0]  walk_type;
  logic [1:0]  walk_verdict;
  bit          walk_live;
  bit          walk_done;

  fmtm_out_t   pending_verdicts[$];
  int          mismatch_count;
  int          sent_count;
  int          cycle_count = 0;
  int          snd_idle_pct;
  int          rcv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int exp_val, input int got_val);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, exp_val,
               got_val);
    mismatch_count++;
  endtask

  // Result side: random ready, compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    fmtm_out_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result, status", -1, out_item.status);
      end else begin
        exp_res = pending_verdicts.pop_front();
        if (out_item.status !== exp_res.status)
          report_mismatch("status", exp_res.status, out_item.status);
        if (out_item.file_type !== exp_res.file_type)
          report_mismatch("file_type", exp_res.file_type, out_item.file_type);
      end
    end
    out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  task automatic rewind_walk();
    walk_node    = 8'd0;
    walk_live    = 1'b1;
    walk_pos     = 16'd0;
    walk_type    = 10'd0;
    walk_verdict = ST_CONTINUE;
    walk_done    = 1'b0;
  endtask

  task automatic predict_verdict(input fmtm_in_t req, output fmtm_out_t res);
    logic [7:0]  node;
    logic [15:0] pos;
    logic [8:0]  entry;
    bit          live;
    res.status    = ST_ACCEPTED;
    res.file_type = '0;
    case (req.cmd)
      CMD_WR_TRANS: begin
        trans_mem[{req.node_index, req.byte_value}] =
          req.next_present ? {1'b1, req.next_index} : 9'd0;
        if (req.next_present) begin
          child_label[req.node_index] = req.byte_value;
          has_child[req.node_index]   = 1'b1;
        end
      end
      CMD_WR_ATTR: begin
        attr_off[req.node_index]    = req.node_offset;
        attr_type[req.node_index]   = req.node_type;
        attr_shared[req.node_index] = req.node_shared;
        if (!attr_written[req.node_index]) written_nodes = {written_nodes, req.node_index};
        attr_written[req.node_index] = 1'b1;
      end
      CMD_START: rewind_walk();
      default: begin
        if (!walk_done) begin
          node = walk_node;
          live = walk_live;
          pos  = walk_pos;
          if (live && attr_off[node] == pos) begin
            if (attr_type[node] != 0) walk_type = attr_type[node];
            entry = trans_mem[{node, req.byte_value}];
            if (entry[8]) node = entry[7:0];
            else live = 1'b0;
          end
          // hold the position at its maximum
          if (pos != 16'hFFFF) walk_pos = pos + 16'd1;
          if (!live) begin
            walk_live    = 1'b0;
            walk_verdict = (walk_type != 0) ? ST_IDENTIFIED : ST_UNKNOWN;
            walk_done    = 1'b1;
          end else if (walk_type != 0 && attr_shared[node]) begin
            walk_verdict = ST_IDENTIFIED;
            walk_done    = 1'b1;
          end else if (attr_off[node] > pos) begin
            walk_node    = node;
            walk_verdict = ST_CONTINUE;
          end else begin
            walk_verdict = ST_UNKNOWN;
            walk_done    = 1'b1;
          end
        end
        res.status    = walk_verdict;
        res.file_type = walk_type;
      end
    endcase
  endtask

  // Present one request and hold it until accepted; valid stays high into the next request
  // unless the sender idles.
  task automatic send_request(input fmtm_in_t req);
    fmtm_out_t res;
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_verdict(req, res);
    pending_verdicts = {pending_verdicts, res};
    sent_count++;
  endtask

  function automatic fmtm_in_t random_request();
    fmtm_in_t req;
    req.cmd          = fmtm_cmd_t'($urandom_range(0, 3));
    req.node_index   = 8'($urandom_range(0, 255));
    req.byte_value   = 8'($urandom_range(0, 255));
    req.next_index   = 8'($urandom_range(0, 255));
    req.next_present = 1'($urandom_range(0, 1));
    req.node_offset  = 16'($urandom_range(0, 65535));
    req.node_type    = 10'($urandom_range(0, 1023));
    req.node_shared  = 1'($urandom_range(0, 1));
    return req;
  endfunction

  task automatic write_attr(input logic [7:0] node, input logic [15:0] off,
                            input logic [9:0] ftype, input logic shared);
    fmtm_in_t req;
    req             = random_request();
    req.cmd         = CMD_WR_ATTR;
    req.node_index  = node;
    req.node_offset = off;
    req.node_type   = ftype;
    req.node_shared = shared;
    send_request(req);
  endtask

  // Targets of present transitions always have attributes written first.
  task automatic write_trans(input logic [7:0] node, input logic [7:0] label,
                             input logic [7:0] target, input logic present);
    fmtm_in_t req;
    req              = random_request();
    req.cmd          = CMD_WR_TRANS;
    req.node_index   = node;
    req.byte_value   = label;
    req.next_index   = target;
    req.next_present = present;
    send_request(req);
  endtask

  task automatic start_file();
    fmtm_in_t req;
    req     = random_request();
    req.cmd = CMD_START;
    send_request(req);
  endtask

  task automatic send_byte(input logic [7:0] value);
    fmtm_in_t req;
    req            = random_request();
    req.cmd        = CMD_DATA;
    req.byte_value = value;
    send_request(req);
  endtask

  task automatic test_directed_walks();
    // byte on a bare root: no transition, no type
    write_attr(8'd0, 16'd0, 10'd0, 1'b0);
    send_byte(8'hFF);
    send_byte(8'h00);                       // latched
    start_file();
    // root -FF-> 255 (type at offset 1) -00-> null: identified
    write_attr(8'd255, 16'd1, 10'd1023, 1'b0);
    write_attr(8'd1, 16'hFFFF, 10'd5, 1'b1);
    write_trans(8'd0, 8'hFF, 8'd255, 1'b1);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h12);                       // latched with type
    // shared child after a recorded type
    start_file();
    write_trans(8'd255, 8'h00, 8'd1, 1'b1);
    send_byte(8'hFF);
    send_byte(8'h00);
    // child whose offset is not ahead
    start_file();
    write_attr(8'd2, 16'd1, 10'd0, 1'b0);
    write_trans(8'd255, 8'h00, 8'd2, 1'b1);
    send_byte(8'hFF);
    send_byte(8'h00);
    // shared node without a recorded type keeps going
    start_file();
    write_trans(8'd0, 8'h80, 8'd1, 1'b1);
    send_byte(8'h80);
    send_byte(8'h3C);
    // overwrite a transition with null
    start_file();
    write_trans(8'd0, 8'hFF, 8'd0, 1'b0);
    send_byte(8'hFF);
  endtask

  // Hold the walk at a root whose offset lies far ahead, then step past it into a child.
  task automatic test_far_offset();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_attr(8'd3, 16'h1234, 10'd0, 1'b0);
    write_attr(8'd0, 16'(FAR_OFFSET), 10'd7, 1'b0);
    write_trans(8'd0, 8'h5A, 8'd3, 1'b1);
    start_file();
    for (int i = 0; i < FAR_OFFSET; i++) send_byte(8'($urandom_range(0, 255)));
    send_byte(8'h5A);
    send_byte(8'h5A);
  endtask

  task automatic build_trie();
    logic [7:0]  members[$];
    logic [7:0]  id;
    logic [7:0]  parent;
    logic [15:0] off;
    logic [9:0]  ftype;
    int          count;
    count = $urandom_range(3, 14);
    members = {members, 8'd0};
    write_attr(8'd0, 16'd0, ($urandom_range(0, 3) == 0) ? 10'($urandom_range(1, 1023)) : 10'd0,
               1'($urandom_range(0, 1)));
    for (int k = 0; k < count; k++) begin
      id     = 8'($urandom_range(1, 255));
      parent = members[$urandom_range(0, members.size() - 1)];
      off    = attr_off[parent] + 16'd1;
      if ($urandom_range(0, 99) < 25) off = off + 16'($urandom_range(1, 3));
      ftype  = ($urandom_range(0, 99) < 35) ? 10'($urandom_range(1, 1023)) : 10'd0;
      write_attr(id, off, ftype, ($urandom_range(0, 99) < 20));
      write_trans(parent, 8'($urandom_range(0, 255)), id, 1'b1);
      members = {members, id};
    end
  endtask

  task automatic noise_burst();
    fmtm_in_t req;
    int       count;
    count = $urandom_range(1, 8);
    for (int k = 0; k < count; k++) begin
      req = random_request();
      if (req.cmd == CMD_WR_TRANS && req.next_present && !attr_written[req.next_index])
        req.next_index = written_nodes[$urandom_range(0, written_nodes.size() - 1)];
      send_request(req);
    end
  endtask

  task automatic walk_file();
    logic [7:0] value;
    int         len;
    // occasionally carry on from the previous walk without a start
    if ($urandom_range(0, 9) != 0) start_file();
    len = $urandom_range(1, 16);
    for (int k = 0; k < len; k++) begin
      if (walk_done) begin
        if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(0, 255)));
        break;
      end
      if ($urandom_range(0, 99) < 6) start_file();
      if (has_child[walk_node] && $urandom_range(0, 99) < 85) value = child_label[walk_node];
      else value = 8'($urandom_range(0, 255));
      send_byte(value);
    end
  endtask

  task automatic test_random_walks(input int snd_pct, input int rcv_pct);
    int first;
    int pick;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    first = sent_count;
    while (sent_count - first < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 12 || !attr_written[0]) build_trie();
      else if (pick < 27) noise_burst();
      else walk_file();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    mismatch_count = 0;
    sent_count     = 0;
    snd_idle_pct   = 23;
    rcv_idle_pct   = 79;
    for (int i = 0; i < 65536; i++) trans_mem[i] = 9'd0;
    for (int i = 0; i < 256; i++) begin
      attr_off[i]     = '0;
      attr_type[i]    = '0;
      attr_shared[i]  = 1'b0;
      attr_written[i] = 1'b0;
      child_label[i]  = '0;
      has_child[i]    = 1'b0;
    end
    rewind_walk();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_walks();
    test_random_walks(23, 79);
    test_random_walks(79, 23);
    test_random_walks(0, 0);
    test_far_offset();
    in_valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
hdl/fmtm_pkg.sv
hdl/fmtm_front.sv
hdl/fmtm_back.sv
hdl/file_magic_trie_matcher.sv
test/file_magic_trie_matcher_tb.sv
